// ===== rtl/small_language_tokenizer_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SMALL_LANGUAGE_TOKENIZER_DEFINES_SVH
`define SMALL_LANGUAGE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SLT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/slt_pkg.sv =====
`default_nettype none
package slt_pkg;

    localparam int KIND_WIDTH = 5;

    // Scan modes
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_NUM  = 2'd2,
        MODE_OP   = 2'd3
    } slt_mode_t;

    // Pending operator codes
    localparam logic [1:0] OP_EQ   = 2'd0;
    localparam logic [1:0] OP_BANG = 2'd1;
    localparam logic [1:0] OP_LT   = 2'd2;
    localparam logic [1:0] OP_GT   = 2'd3;

    // Token kinds
    localparam logic [KIND_WIDTH-1:0] KIND_EOF    = 5'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_EQ     = 5'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_NEQ    = 5'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_LEQ    = 5'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_GEQ    = 5'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_ASSIGN = 5'd5;
    localparam logic [KIND_WIDTH-1:0] KIND_PLUS   = 5'd6;
    localparam logic [KIND_WIDTH-1:0] KIND_MINUS  = 5'd7;
    localparam logic [KIND_WIDTH-1:0] KIND_STAR   = 5'd8;
    localparam logic [KIND_WIDTH-1:0] KIND_SLASH  = 5'd9;
    localparam logic [KIND_WIDTH-1:0] KIND_LT     = 5'd10;
    localparam logic [KIND_WIDTH-1:0] KIND_GT     = 5'd11;
    localparam logic [KIND_WIDTH-1:0] KIND_SEMI   = 5'd12;
    localparam logic [KIND_WIDTH-1:0] KIND_LPAREN = 5'd13;
    localparam logic [KIND_WIDTH-1:0] KIND_RPAREN = 5'd14;
    localparam logic [KIND_WIDTH-1:0] KIND_LBRACE = 5'd15;
    localparam logic [KIND_WIDTH-1:0] KIND_RBRACE = 5'd16;
    localparam logic [KIND_WIDTH-1:0] KIND_WHILE  = 5'd17;
    localparam logic [KIND_WIDTH-1:0] KIND_PRINT  = 5'd18;
    localparam logic [KIND_WIDTH-1:0] KIND_ELSE   = 5'd19;
    localparam logic [KIND_WIDTH-1:0] KIND_INT    = 5'd20;
    localparam logic [KIND_WIDTH-1:0] KIND_IF     = 5'd21;
    localparam logic [KIND_WIDTH-1:0] KIND_IDENT  = 5'd22;
    localparam logic [KIND_WIDTH-1:0] KIND_NUMBER = 5'd23;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keywords packed as their bytes, first byte most significant
    localparam logic [39:0] KW_WHILE = 40'h7768696C65;
    localparam logic [39:0] KW_PRINT = 40'h7072696E74;
    localparam logic [39:0] KW_ELSE  = 40'h00656C7365;
    localparam logic [39:0] KW_INT   = 40'h0000696E74;
    localparam logic [39:0] KW_IF    = 40'h0000006966;

    // Push request from the scanner to the result queue
    typedef struct packed {
        logic a;
        logic b;
    } slt_push_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [KIND_WIDTH-1:0] two_kind(input logic [1:0] op);
        logic [KIND_WIDTH-1:0] k;
        unique case (op)
            OP_EQ:   k = KIND_EQ;
            OP_BANG: k = KIND_NEQ;
            OP_LT:   k = KIND_LEQ;
            default: k = KIND_GEQ;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_WIDTH-1:0] one_kind(input logic [1:0] op);
        logic [KIND_WIDTH-1:0] k;
        unique case (op)
            OP_EQ:   k = KIND_ASSIGN;
            OP_LT:   k = KIND_LT;
            OP_GT:   k = KIND_GT;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/slt_step.sv =====
`default_nettype none
module slt_step #(
    parameter int POS_WIDTH = 32,
    parameter int LEN_WIDTH = 16,
    localparam int RES_WIDTH = slt_pkg::KIND_WIDTH + POS_WIDTH + LEN_WIDTH + 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire logic [7:0]           char_code,
    input  wire logic [1:0]           free,
    output      slt_pkg::slt_push_t   push,
    output      logic [RES_WIDTH-1:0] res_a,
    output      logic [RES_WIDTH-1:0] res_b
);
    import slt_pkg::*;

    logic                  in_valid_reg;
    logic [7:0]            char_reg;
    slt_mode_t             mode_reg, mode_next;
    logic [1:0]            pend_reg, pend_next;
    logic [POS_WIDTH-1:0]  pos_reg, pos_next;
    logic [POS_WIDTH-1:0]  tstart_reg, tstart_next;
    logic [LEN_WIDTH-1:0]  tlen_reg, tlen_next;
    logic [39:0]           wpref_reg, wpref_next;

    logic                  fire;
    logic [1:0]            need;
    logic                  scan;
    logic                  word_ch;
    logic [LEN_WIDTH-1:0]  tlen_sat;
    logic [KIND_WIDTH-1:0] word_kind;

    logic                  a_valid, b_valid;
    logic [KIND_WIDTH-1:0] a_kind, b_kind;
    logic [POS_WIDTH-1:0]  a_start, b_start;
    logic [LEN_WIDTH-1:0]  a_len, b_len;

    // Take the held byte only when the queue has room for all its results
    assign need     = {1'b0, a_valid} + {1'b0, b_valid};
    assign fire     = in_valid_reg && (need <= free);
    assign in_stall = in_valid_reg && !fire;

    assign push.a = fire && a_valid;
    assign push.b = fire && b_valid;
    assign res_a  = {a_kind, a_start, a_len, !b_valid};
    assign res_b  = {b_kind, b_start, b_len, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= char_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= OP_EQ;
            pos_reg   <= '0;
            tlen_reg  <= '0;
            wpref_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            tlen_reg  <= tlen_next;
            wpref_reg <= wpref_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            tstart_reg <= tstart_next;
        end
    end

    assign word_ch  = is_alpha(char_reg) || is_digit(char_reg) || (char_reg == CH_UNDER);
    assign tlen_sat = (tlen_reg == {LEN_WIDTH{1'b1}}) ? tlen_reg : tlen_reg + LEN_WIDTH'(1);

    always_comb
    begin
        if ((tlen_reg == LEN_WIDTH'(5)) && (wpref_reg == KW_WHILE))
            word_kind = KIND_WHILE;
        else if ((tlen_reg == LEN_WIDTH'(5)) && (wpref_reg == KW_PRINT))
            word_kind = KIND_PRINT;
        else if ((tlen_reg == LEN_WIDTH'(4)) && (wpref_reg == KW_ELSE))
            word_kind = KIND_ELSE;
        else if ((tlen_reg == LEN_WIDTH'(3)) && (wpref_reg == KW_INT))
            word_kind = KIND_INT;
        else if ((tlen_reg == LEN_WIDTH'(2)) && (wpref_reg == KW_IF))
            word_kind = KIND_IF;
        else
            word_kind = KIND_IDENT;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        pos_next    = pos_reg + POS_WIDTH'(1);
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        wpref_next  = wpref_reg;
        scan        = 1'b1;
        a_valid     = 1'b0;
        a_kind      = KIND_EOF;
        a_start     = tstart_reg;
        a_len       = '0;
        b_valid     = 1'b0;
        b_kind      = KIND_EOF;
        b_start     = pos_reg;
        b_len       = LEN_WIDTH'(1);

        // Close or extend the open token
        unique case (mode_reg)
            MODE_OP:
            begin
                mode_next = MODE_IDLE;
                if (char_reg == CH_EQ)
                begin
                    a_valid = 1'b1;
                    a_kind  = two_kind(pend_reg);
                    a_len   = LEN_WIDTH'(2);
                    scan    = 1'b0;
                end
                else if (pend_reg != OP_BANG)
                begin
                    a_valid = 1'b1;
                    a_kind  = one_kind(pend_reg);
                    a_len   = LEN_WIDTH'(1);
                end
            end
            MODE_WORD:
            begin
                if (word_ch)
                begin
                    if (tlen_reg < LEN_WIDTH'(5))
                        wpref_next = {wpref_reg[31:0], char_reg};
                    tlen_next = tlen_sat;
                    scan      = 1'b0;
                end
                else
                begin
                    a_valid   = 1'b1;
                    a_kind    = word_kind;
                    a_len     = tlen_reg;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUM:
            begin
                if (is_digit(char_reg))
                begin
                    tlen_next = tlen_sat;
                    scan      = 1'b0;
                end
                else
                begin
                    a_valid   = 1'b1;
                    a_kind    = KIND_NUMBER;
                    a_len     = tlen_reg;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_IDLE:
            begin
            end
        endcase

        // Classify the byte itself
        if (scan)
        begin
            unique case (char_reg)
                CH_NUL:
                begin
                    b_valid    = 1'b1;
                    b_kind     = KIND_EOF;
                    b_len      = '0;
                    mode_next  = MODE_IDLE;
                    pend_next  = OP_EQ;
                    pos_next   = '0;
                    tlen_next  = '0;
                    wpref_next = '0;
                end
                CH_EQ:
                begin
                    pend_next   = OP_EQ;
                    mode_next   = MODE_OP;
                    tstart_next = pos_reg;
                end
                CH_BANG:
                begin
                    pend_next   = OP_BANG;
                    mode_next   = MODE_OP;
                    tstart_next = pos_reg;
                end
                CH_LT:
                begin
                    pend_next   = OP_LT;
                    mode_next   = MODE_OP;
                    tstart_next = pos_reg;
                end
                CH_GT:
                begin
                    pend_next   = OP_GT;
                    mode_next   = MODE_OP;
                    tstart_next = pos_reg;
                end
                CH_PLUS:   begin b_valid = 1'b1; b_kind = KIND_PLUS;   end
                CH_MINUS:  begin b_valid = 1'b1; b_kind = KIND_MINUS;  end
                CH_STAR:   begin b_valid = 1'b1; b_kind = KIND_STAR;   end
                CH_SLASH:  begin b_valid = 1'b1; b_kind = KIND_SLASH;  end
                CH_SEMI:   begin b_valid = 1'b1; b_kind = KIND_SEMI;   end
                CH_LPAREN: begin b_valid = 1'b1; b_kind = KIND_LPAREN; end
                CH_RPAREN: begin b_valid = 1'b1; b_kind = KIND_RPAREN; end
                CH_LBRACE: begin b_valid = 1'b1; b_kind = KIND_LBRACE; end
                CH_RBRACE: begin b_valid = 1'b1; b_kind = KIND_RBRACE; end
                default:
                begin
                    if (is_alpha(char_reg) || (char_reg == CH_UNDER))
                    begin
                        mode_next   = MODE_WORD;
                        tstart_next = pos_reg;
                        tlen_next   = LEN_WIDTH'(1);
                        wpref_next  = {32'h0, char_reg};
                    end
                    else if (is_digit(char_reg))
                    begin
                        mode_next   = MODE_NUM;
                        tstart_next = pos_reg;
                        tlen_next   = LEN_WIDTH'(1);
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/slt_outq.sv =====
`default_nettype none
module slt_outq #(
    parameter int DATA_WIDTH = 54
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire slt_pkg::slt_push_t    push,
    input  wire logic [DATA_WIDTH-1:0] data_a,
    input  wire logic [DATA_WIDTH-1:0] data_b,
    output      logic [1:0]            free,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic [DATA_WIDTH-1:0] out_data
);
    import slt_pkg::*;

    logic [DATA_WIDTH-1:0] slot0_reg, slot0_next;
    logic [DATA_WIDTH-1:0] slot1_reg, slot1_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic                  pop;
    logic [1:0]            base;
    logic [1:0]            npush;
    logic [DATA_WIDTH-1:0] first;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign pop       = out_valid && !out_stall;
    assign free      = 2'd2 - cnt_reg + {1'b0, pop};
    assign base      = cnt_reg - {1'b0, pop};
    assign npush     = {1'b0, push.a} + {1'b0, push.b};
    assign first     = push.a ? data_a : data_b;
    assign cnt_next  = base + npush;

    // Drop the head on pop, then append new words behind what stays
    always_comb
    begin
        case (base)
            2'd0:
            begin
                slot0_next = first;
                slot1_next = data_b;
            end
            2'd1:
            begin
                slot0_next = pop ? slot1_reg : slot0_reg;
                slot1_next = first;
            end
            default:
            begin
                slot0_next = slot0_reg;
                slot1_next = slot1_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule
`default_nettype wire

// ===== rtl/small_language_tokenizer.sv =====
// Path: an accepted byte is held in the input register and classified from it; its
//   token words are then written into the result queue, whose head drives the output.
// Throughput: one byte per cycle unless in_stall is raised; a byte that closes one token
//   and is itself a token yields two words, sent one per cycle by the output port.
// Reset: rst_n is asynchronous and active low; it empties both stages and returns
//   the scanner to offset 0 of a new text, between tokens.
`default_nettype none
module small_language_tokenizer #(
    parameter int POS_WIDTH = 32,
    parameter int LEN_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [7:0]                    char_code,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [slt_pkg::KIND_WIDTH-1:0] token_kind,
    output      logic [POS_WIDTH-1:0]          start_pos,
    output      logic [LEN_WIDTH-1:0]          token_len,
    output      logic                          last_of_run
);
    import slt_pkg::*;

    // One result word: kind, start offset, length, last-of-run flag
    localparam int RES_WIDTH = KIND_WIDTH + POS_WIDTH + LEN_WIDTH + 1;

    slt_push_t            push;
    logic [1:0]           free;
    logic [RES_WIDTH-1:0] res_a;
    logic [RES_WIDTH-1:0] res_b;
    logic [RES_WIDTH-1:0] head;

    // Scanner: holds one byte, closes the open token and classifies the byte.
    // It advances only when the queue can take every word the byte produces,
    // so a byte that yields two tokens holds the input while the queue has
    // room for only one word.
    slt_step #(
        .POS_WIDTH (POS_WIDTH),
        .LEN_WIDTH (LEN_WIDTH)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .free      (free),
        .push      (push),
        .res_a     (res_a),
        .res_b     (res_b)
    );

    // Two-entry result queue: decouples the output stall from the scanner and
    // keeps the order of the words of one byte (closed token first).
    slt_outq #(
        .DATA_WIDTH (RES_WIDTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_a    (res_a),
        .data_b    (res_b),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (head)
    );

    // Split the head word into its fields
    assign token_kind  = head[RES_WIDTH-1 -: KIND_WIDTH];
    assign start_pos   = head[LEN_WIDTH+1 +: POS_WIDTH];
    assign token_len   = head[1 +: LEN_WIDTH];
    assign last_of_run = head[0];

endmodule
`default_nettype wire

// ===== rtl/slt_checker.sv =====
`default_nettype none
`include "small_language_tokenizer_defines.svh"
module slt_checker #(
    parameter int POS_WIDTH = 32,
    parameter int LEN_WIDTH = 16
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [slt_pkg::KIND_WIDTH-1:0] token_kind,
    input wire logic [POS_WIDTH-1:0]           start_pos,
    input wire logic [LEN_WIDTH-1:0]           token_len,
    input wire logic                           last_of_run
);
    import slt_pkg::*;

    // A stalled word holds
    `SLT_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(token_kind) && $stable(start_pos) && $stable(token_len) && $stable(last_of_run), "stalled result word changed")

    // End of text closes the run with zero length
    `SLT_ASSERT_NOW(a_eof, out_valid && (token_kind == KIND_EOF), (token_len == '0) && last_of_run, "eof word malformed")

    // Every real token has nonzero length
    `SLT_ASSERT_NOW(a_len, out_valid && (token_kind != KIND_EOF), token_len != '0, "token with zero length")

    // Two-character operators are two bytes long
    `SLT_ASSERT_NOW(a_pair, out_valid && ((token_kind == KIND_EQ) || (token_kind == KIND_NEQ) || (token_kind == KIND_LEQ) || (token_kind == KIND_GEQ)), token_len == LEN_WIDTH'(2), "two-byte operator length wrong")

endmodule

bind small_language_tokenizer slt_checker #(
    .POS_WIDTH (POS_WIDTH),
    .LEN_WIDTH (LEN_WIDTH)
) u_slt_checker (.*);
`default_nettype wire
